FILE: src/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the line substring matcher
// Input kinds, register indexes, saturation limits and the ASCII case fold.
// ----------------------------------------------------------------------------
package lsm_pkg;

	localparam int unsigned MAX_PATTERN_DEF = 16;
	localparam int unsigned PAT_BYTES       = 16;

	localparam logic [15:0] MATCH_LIMIT_RST = 16'd1000;
	localparam logic [15:0] COL_MAX         = 16'hFFFF;
	localparam logic [19:0] LINE_MAX        = 20'hFFFFF;
	localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

	typedef enum logic [1:0] {
		FUNC_TEXT = 2'd0,
		FUNC_EOL  = 2'd1,
		FUNC_EOF  = 2'd2,
		FUNC_NEW  = 2'd3
	} func_t;

	localparam logic [2:0] REG_PAT_LO     = 3'd0;
	localparam logic [2:0] REG_PAT_HI     = 3'd1;
	localparam logic [2:0] REG_PAT_LEN    = 3'd2;
	localparam logic [2:0] REG_CASE_SENS  = 3'd3;
	localparam logic [2:0] REG_MATCH_LIM  = 3'd4;

	// Shift and clear commands broadcast to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic case_sens);
		logic [7:0] r;
		r = c;
		if (!case_sens && c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

FILE: src/lsm_cell.sv
// ----------------------------------------------------------------------------
// lsm_cell: one byte of the text window
// Holds one window byte, passes it to its neighbor on every shift and
// compares the byte it is about to take against its pattern byte.
// ----------------------------------------------------------------------------
module lsm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lsm_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]        d_in,
	input  logic [7:0]        pat_byte,
	input  logic              in_use,
	input  logic              case_sens,
	output logic [7:0]        d_out,
	output logic              eq
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= d_in;
		end
	end

	assign d_out = byte_q;

	// Cells beyond the pattern length never block a hit.
	assign eq = !in_use ||
		(lsm_pkg::fold(d_in, case_sens) == lsm_pkg::fold(pat_byte, case_sens));

endmodule

FILE: src/line_substring_matcher_core.sv
// ----------------------------------------------------------------------------
// line_substring_matcher_core: streaming fixed-pattern line matcher
// Finds non-overlapping pattern occurrences within each text line and
// reports line number and start column of each one, up to the match limit.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat content
//  s_axis    in         tdata: text byte; tuser: kind (text, eol, eof, new search)
//  m_axis    out        tdata: line number, start column; tuser: limit flag
//  cfg       in         write enable, register index, 64-bit write data
//
// One beat is taken per cycle. The window cells shift and compare in the
// cycle a text beat is accepted, and a hit lands in the output register
// at the next edge. The column, allowed-start and match counters close
// a loop through their own registers, which sets this figure. The input
// stalls only while a result sits in the output register and m_axis_tready
// is low. Reset takes effect at once; no clearing pass follows it.
module line_substring_matcher_core #(
	parameter int unsigned MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [19:0] line_number, [35:20] start_column
	output logic [0:0]  m_axis_tuser    // [0] limit_reached
);

	localparam int unsigned PAT_W = 8 * lsm_pkg::PAT_BYTES;

	// Configuration registers.
	logic [PAT_W-1:0] pattern_q;
	logic [4:0]       pat_len_q;
	logic             case_sens_q;
	logic [15:0]      match_limit_q;

	// Search state.
	logic [15:0] col_q;
	logic [19:0] line_q;
	logic [15:0] nas_q;
	logic [15:0] found_q;
	logic        stopped_q;

	// Output register.
	logic        out_valid_q;
	logic [19:0] out_line_q;
	logic [15:0] out_col_q;
	logic        out_lim_q;

	logic                in_acc;
	lsm_pkg::func_t      func;
	lsm_pkg::cell_ctrl_t cell_ctrl;
	logic [4:0]          len_eff;
	logic                overlong;
	logic [15:0]         col_next;
	logic [15:0]         start;
	logic [15:0]         found_next;
	logic                hit;
	logic [MAX_PATTERN-1:0] cell_eq;
	logic [7:0]          chain [MAX_PATTERN+1];

	assign func   = lsm_pkg::func_t'(s_axis_tuser);
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			pat_len_q     <= '0;
			case_sens_q   <= 1'b0;
			match_limit_q <= lsm_pkg::MATCH_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				lsm_pkg::REG_PAT_LO:    pattern_q[63:0]   <= cfg_wdata;
				lsm_pkg::REG_PAT_HI:    pattern_q[127:64] <= cfg_wdata;
				lsm_pkg::REG_PAT_LEN:   pat_len_q         <= cfg_wdata[4:0];
				lsm_pkg::REG_CASE_SENS: case_sens_q       <= cfg_wdata[0];
				lsm_pkg::REG_MATCH_LIM: match_limit_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign len_eff = (pat_len_q > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : pat_len_q;

	assign cell_ctrl.shift = in_acc && (func == lsm_pkg::FUNC_TEXT);
	assign cell_ctrl.clear = in_acc && (func != lsm_pkg::FUNC_TEXT);

	// Cell 0 holds the newest byte; cell w is compared with pattern byte len-1-w.
	assign chain[0] = s_axis_tdata;

	for (genvar w = 0; w < MAX_PATTERN; w++) begin : g_cell
		logic [4:0] pidx;
		logic       use_w;

		assign pidx  = len_eff - 5'(w) - 5'd1;
		assign use_w = 5'(w) < len_eff;

		lsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.d_in      (chain[w]),
			.pat_byte  (pattern_q[8*pidx[3:0] +: 8]),
			.in_use    (use_w),
			.case_sens (case_sens_q),
			.d_out     (chain[w+1]),
			.eq        (cell_eq[w])
		);
	end

	assign overlong   = (col_q == lsm_pkg::COL_MAX);
	assign col_next   = overlong ? col_q : col_q + 16'd1;
	assign start      = col_next - {11'd0, len_eff};
	assign found_next = (found_q == lsm_pkg::COUNT_MAX) ? found_q : found_q + 16'd1;

	assign hit = cell_ctrl.shift && !stopped_q && !overlong && (len_eff != 5'd0) &&
		(col_next >= {11'd0, len_eff}) && (start >= nas_q) && (&cell_eq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			line_q    <= 20'd1;
			nas_q     <= '0;
			found_q   <= '0;
			stopped_q <= 1'b0;
		end else if (in_acc) begin
			case (func)
				lsm_pkg::FUNC_TEXT: begin
					col_q <= col_next;
					if (hit) begin
						nas_q   <= col_next;
						found_q <= found_next;
						if (found_next >= match_limit_q) begin
							stopped_q <= 1'b1;
						end
					end
				end
				lsm_pkg::FUNC_EOL: begin
					col_q <= '0;
					nas_q <= '0;
					if (line_q != lsm_pkg::LINE_MAX) begin
						line_q <= line_q + 20'd1;
					end
				end
				lsm_pkg::FUNC_EOF: begin
					col_q  <= '0;
					nas_q  <= '0;
					line_q <= 20'd1;
				end
				lsm_pkg::FUNC_NEW: begin
					col_q     <= '0;
					nas_q     <= '0;
					line_q    <= 20'd1;
					found_q   <= '0;
					stopped_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && hit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && hit) begin
			out_line_q <= line_q;
			out_col_q  <= start;
			out_lim_q  <= (found_next >= match_limit_q);
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {4'd0, out_col_q, out_line_q};
	assign m_axis_tuser[0] = out_lim_q;

	// A new result only follows an accepted text beat.
	a_res_from_text: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_acc && (func == lsm_pkg::FUNC_TEXT)))
		else $error("result without a text beat");

	// Once stopped, the search reports nothing more.
	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !hit)
		else $error("hit while stopped");

	// No match can start at the saturated column.
	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (start != lsm_pkg::COL_MAX))
		else $error("start column out of range");

	// Any line marker clears the column and the allowed start.
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (func != lsm_pkg::FUNC_TEXT)) |=> (col_q == '0 && nas_q == '0))
		else $error("line state not cleared");

	// A result flagged as reaching the limit leaves the matcher stopped.
	a_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> stopped_q)
		else $error("limit flag without stop");

endmodule
